// ----- design/sps_pkg.sv -----
// shared types, codes and phase tables for the stimulation phase sequencer
// no dependencies; used by stimulation_phase_sequencer
package sps_pkg;

  // device modes
  localparam logic [1:0] MODE_SLEEP   = 2'd0;
  localparam logic [1:0] MODE_WAKEUP  = 2'd1;
  localparam logic [1:0] MODE_RUNNING = 2'd2;
  localparam logic [1:0] MODE_PAUSE   = 2'd3;

  // input commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_POWER = 2'd1;
  localparam logic [1:0] CMD_WAVE  = 2'd2;

  // beep requests
  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_ONE  = 2'd1;
  localparam logic [1:0] BEEP_TWO  = 2'd2;
  localparam logic [1:0] BEEP_LONG = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
  localparam logic [2:0] REG_TOGGLE      = 3'd1;
  localparam logic [2:0] REG_PAUSE_TOUT  = 3'd2;
  localparam logic [2:0] REG_TICKS_UNIT  = 3'd3;
  localparam logic [2:0] REG_RUN_FLASH   = 3'd4;
  localparam logic [2:0] REG_PAUSE_FLASH = 3'd5;

  // reset values
  localparam logic [9:0]  LONG_PRESS_RST  = 10'd300;
  localparam logic [9:0]  TOGGLE_RST      = 10'd100;
  localparam logic [16:0] PAUSE_TOUT_RST  = 17'd90000;
  localparam logic [7:0]  TICKS_UNIT_RST  = 8'd100;
  localparam logic [6:0]  RUN_FLASH_RST   = 7'd30;
  localparam logic [6:0]  PAUSE_FLASH_RST = 7'd70;
  localparam logic [11:0] HIGH_CODE_RST   = 12'd4000;

  // result item, packed highest field first
  typedef struct packed {
    logic [1:0]  pad;
    logic [1:0]  beep_kind;
    logic        led_short;
    logic        led_long;
    logic        buzzer_on;
    logic        short_wave;
    logic [11:0] level_high;
    logic [11:0] level_low;
    logic        period_timer_on;
    logic [15:0] period_value;
    logic [4:0]  phase_number;
    logic [1:0]  device_mode;
  } result_t;

  // phase length in units, long wave
  function automatic logic [8:0] dur_long(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:  v = 9'd30;
      5'd1:  v = 9'd5;
      5'd2:  v = 9'd30;
      5'd3:  v = 9'd5;
      5'd4:  v = 9'd240;
      5'd5:  v = 9'd2;
      5'd6:  v = 9'd180;
      5'd7:  v = 9'd3;
      5'd8:  v = 9'd180;
      5'd9:  v = 9'd5;
      5'd10: v = 9'd120;
      5'd11: v = 9'd5;
      5'd12: v = 9'd360;
      5'd13: v = 9'd360;
      5'd14: v = 9'd90;
      5'd15: v = 9'd5;
      5'd16: v = 9'd90;
      5'd17: v = 9'd90;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // phase length in units, short wave
  function automatic logic [8:0] dur_short(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:  v = 9'd30;
      5'd1:  v = 9'd5;
      5'd2:  v = 9'd30;
      5'd3:  v = 9'd5;
      5'd4:  v = 9'd120;
      5'd5:  v = 9'd2;
      5'd6:  v = 9'd90;
      5'd7:  v = 9'd3;
      5'd8:  v = 9'd90;
      5'd9:  v = 9'd5;
      5'd10: v = 9'd60;
      5'd11: v = 9'd5;
      5'd12: v = 9'd180;
      5'd13: v = 9'd180;
      5'd14: v = 9'd30;
      5'd15: v = 9'd5;
      5'd16: v = 9'd30;
      5'd17: v = 9'd30;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // timer period per phase, zero marks a gap phase
  function automatic logic [15:0] period_of(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd13;
      5'd2:  v = 16'd16;
      5'd4:  v = 16'd26;
      5'd6:  v = 16'd390;
      5'd8:  v = 16'd781;
      5'd10: v = 16'hFFFF;
      5'd12: v = 16'd781;
      5'd13: v = 16'd9700;
      5'd14: v = 16'd26000;
      5'd16: v = 16'd78;
      5'd17: v = 16'd1562;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // dac code per phase
  function automatic logic [11:0] code_of(input logic [4:0] idx);
    logic [11:0] v;
    case (idx)
      5'd0, 5'd2, 5'd4, 5'd8:   v = 12'd2203;
      5'd1, 5'd3, 5'd5, 5'd7,
      5'd9, 5'd11, 5'd15:       v = 12'd1975;
      5'd6, 5'd17:              v = 12'd3015;
      5'd10, 5'd13:             v = 12'd2796;
      5'd12, 5'd14, 5'd16:      v = 12'd2532;
      default:                  v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/stimulation_phase_sequencer.sv -----
// stimulation phase sequencer: mode machine, press classifier, phase stepping
// depends on sps_pkg
//
// channel  dir  handshake                 content
// s_*      in   s_tvalid / s_tready       tuser: cmd; tdata: power_released, wave_button_held
// m_*      out  m_tvalid / m_tready       tdata: one result item (see port comment)
// apb      in   psel, penable, pwrite     six configuration registers at 4*i
//
// each transfer is registered in the input register, then evaluated into the
// output register; one item per cycle sustained while m_tready stays high.
// the rate is set by the single evaluation stage, which updates all state at once.
// rst is synchronous and restores all state and register reset values.
// a stalled output holds its item; one further item waits in the input register.
module stimulation_phase_sequencer #(
  parameter int NUM_PHASES = 18
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] power_released, [1] wave_button_held
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [1:0] device_mode, [6:2] phase_number,
                                 // [22:7] period_value, [23] period_timer_on,
                                 // [35:24] level_low, [47:36] level_high,
                                 // [48] short_wave, [49] buzzer_on, [50] led_long,
                                 // [51] led_short, [53:52] beep_kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [9:0]  long_press_ticks;
  logic [9:0]  toggle_press_ticks;
  logic [16:0] pause_timeout_ticks;
  logic [7:0]  ticks_per_unit;
  logic [6:0]  run_flash_ticks;
  logic [6:0]  pause_flash_ticks;

  // input register
  logic       in_valid;
  logic [1:0] in_cmd;
  logic       in_released;
  logic       in_wave_held;

  // sequencer state
  logic [1:0]  mode_reg;
  logic [4:0]  phase_reg;
  logic [15:0] phase_ticks;
  logic [8:0]  phase_units;
  logic [11:0] low_code;
  logic [11:0] high_code;
  logic        wave_reg;
  logic        buzz_enable;
  logic [9:0]  press_ticks;
  logic        press_armed;
  logic [16:0] pause_ticks;
  logic [6:0]  flash_ticks;
  logic        flash_level;
  logic        timer_on;
  logic        led_lit;

  // next values
  logic [1:0]  mode_next;
  logic [4:0]  phase_next;
  logic [15:0] phase_ticks_next;
  logic [8:0]  phase_units_next;
  logic [11:0] low_code_next;
  logic [11:0] high_code_next;
  logic        wave_next;
  logic        buzz_next;
  logic [9:0]  press_ticks_next;
  logic        press_armed_next;
  logic [16:0] pause_ticks_next;
  logic [6:0]  flash_ticks_next;
  logic        flash_level_next;
  logic        timer_on_next;
  logic        led_lit_next;
  logic [1:0]  beep_next;

  sps_pkg::result_t result;
  logic             advance;
  logic             cfg_write;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign pready   = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks    <= sps_pkg::LONG_PRESS_RST;
      toggle_press_ticks  <= sps_pkg::TOGGLE_RST;
      pause_timeout_ticks <= sps_pkg::PAUSE_TOUT_RST;
      ticks_per_unit      <= sps_pkg::TICKS_UNIT_RST;
      run_flash_ticks     <= sps_pkg::RUN_FLASH_RST;
      pause_flash_ticks   <= sps_pkg::PAUSE_FLASH_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        sps_pkg::REG_LONG_PRESS:  long_press_ticks    <= pwdata[9:0];
        sps_pkg::REG_TOGGLE:      toggle_press_ticks  <= pwdata[9:0];
        sps_pkg::REG_PAUSE_TOUT:  pause_timeout_ticks <= pwdata[16:0];
        sps_pkg::REG_TICKS_UNIT:  ticks_per_unit      <= pwdata[7:0];
        sps_pkg::REG_RUN_FLASH:   run_flash_ticks     <= pwdata[6:0];
        sps_pkg::REG_PAUSE_FLASH: pause_flash_ticks   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    case (paddr[4:2])
      sps_pkg::REG_LONG_PRESS:  prdata = {22'd0, long_press_ticks};
      sps_pkg::REG_TOGGLE:      prdata = {22'd0, toggle_press_ticks};
      sps_pkg::REG_PAUSE_TOUT:  prdata = {15'd0, pause_timeout_ticks};
      sps_pkg::REG_TICKS_UNIT:  prdata = {24'd0, ticks_per_unit};
      sps_pkg::REG_RUN_FLASH:   prdata = {25'd0, run_flash_ticks};
      sps_pkg::REG_PAUSE_FLASH: prdata = {25'd0, pause_flash_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_cmd       <= s_tuser;
      in_released  <= s_tdata[0];
      in_wave_held <= s_tdata[1];
    end
  end

  // one step of the sequencer
  always_comb begin
    logic        wake;
    logic        run;
    logic        pause;
    logic        sleep;
    logic [16:0] product;
    logic [15:0] target;
    logic [6:0]  interval;
    logic        sel;

    wake = 1'b0;
    run = 1'b0;
    pause = 1'b0;
    sleep = 1'b0;
    product = 17'(phase_units) * 17'(ticks_per_unit);
    target = (product > 17'h0FFFF) ? 16'hFFFF : product[15:0];
    interval = (mode_reg == sps_pkg::MODE_RUNNING) ? run_flash_ticks : pause_flash_ticks;

    mode_next        = mode_reg;
    phase_next       = phase_reg;
    phase_ticks_next = phase_ticks;
    phase_units_next = phase_units;
    low_code_next    = low_code;
    high_code_next   = high_code;
    wave_next        = wave_reg;
    buzz_next        = buzz_enable;
    press_ticks_next = press_ticks;
    press_armed_next = press_armed;
    pause_ticks_next = pause_ticks;
    flash_ticks_next = flash_ticks;
    flash_level_next = flash_level;
    timer_on_next    = timer_on;
    led_lit_next     = led_lit;
    beep_next        = sps_pkg::BEEP_NONE;

    case (in_cmd)
      sps_pkg::CMD_POWER: begin
        press_armed_next = 1'b1;
        press_ticks_next = 10'd0;
      end
      sps_pkg::CMD_WAVE: begin
        if (mode_reg != sps_pkg::MODE_SLEEP) begin
          if (buzz_next) beep_next = sps_pkg::BEEP_ONE;
          wave_next = !wave_reg;
          led_lit_next = 1'b1;
        end
      end
      sps_pkg::CMD_TICK: begin
        // press classifier
        if (press_armed) begin
          if (press_ticks != 10'h3FF) press_ticks_next = press_ticks + 10'd1;
          if (press_ticks_next == long_press_ticks) begin
            press_armed_next = 1'b0;
            if (mode_reg == sps_pkg::MODE_WAKEUP) sleep = 1'b1;
            else if (mode_reg == sps_pkg::MODE_RUNNING || mode_reg == sps_pkg::MODE_SLEEP)
              wake = 1'b1;
          end else if (mode_reg != sps_pkg::MODE_SLEEP &&
                       press_ticks_next == toggle_press_ticks && in_wave_held) begin
            press_armed_next = 1'b0;
            buzz_next = !buzz_enable;
          end else if (in_released) begin
            press_armed_next = 1'b0;
            if (mode_reg == sps_pkg::MODE_SLEEP) sleep = 1'b1;
            else if (mode_reg == sps_pkg::MODE_RUNNING) pause = 1'b1;
            else run = 1'b1;
          end
        end

        // phase stepping while running
        if (mode_reg == sps_pkg::MODE_RUNNING) begin
          if (phase_ticks != 16'hFFFF) phase_ticks_next = phase_ticks + 16'd1;
          if (phase_ticks_next >= target) begin
            if (int'(phase_reg) + 1 < NUM_PHASES) begin
              phase_next = phase_reg + 5'd1;
              phase_ticks_next = 16'd0;
              phase_units_next = wave_reg ? sps_pkg::dur_short(phase_next)
                                          : sps_pkg::dur_long(phase_next);
              if (sps_pkg::period_of(phase_next) == 16'd0) begin
                timer_on_next = 1'b0;
              end else begin
                high_code_next = sps_pkg::code_of(phase_next);
                timer_on_next = 1'b1;
              end
            end else begin
              wake = 1'b1;
              timer_on_next = 1'b0;
            end
          end
        end

        // pause timeout
        if (mode_reg == sps_pkg::MODE_PAUSE) begin
          if (pause_ticks != 17'h1FFFF) pause_ticks_next = pause_ticks + 17'd1;
          if (pause_ticks_next >= pause_timeout_ticks) begin
            if (buzz_next) beep_next = sps_pkg::BEEP_LONG;
            sleep = 1'b1;
          end
        end

        // led flashing
        if (mode_reg == sps_pkg::MODE_RUNNING || mode_reg == sps_pkg::MODE_PAUSE) begin
          if (flash_ticks != 7'd127) flash_ticks_next = flash_ticks + 7'd1;
          if (flash_ticks_next >= interval) begin
            flash_ticks_next = 7'd0;
            led_lit_next = flash_level;
            flash_level_next = !flash_level;
          end
        end

        // mode changes in fixed order
        if (wake) begin
          led_lit_next = 1'b1;
          if (mode_next == sps_pkg::MODE_SLEEP) begin
            if (buzz_next) beep_next = sps_pkg::BEEP_LONG;
          end else if (mode_next == sps_pkg::MODE_RUNNING) begin
            timer_on_next = 1'b0;
            if (buzz_next) beep_next = sps_pkg::BEEP_TWO;
          end
          mode_next = sps_pkg::MODE_WAKEUP;
        end
        if (run) begin
          if (mode_next == sps_pkg::MODE_WAKEUP) begin
            phase_next = 5'd0;
            phase_ticks_next = 16'd0;
            phase_units_next = wave_next ? sps_pkg::dur_short(5'd0) : sps_pkg::dur_long(5'd0);
            low_code_next = sps_pkg::code_of(5'd1);
            high_code_next = sps_pkg::code_of(5'd0);
            if (buzz_next) beep_next = sps_pkg::BEEP_TWO;
            timer_on_next = 1'b1;
          end else if (mode_next == sps_pkg::MODE_PAUSE) begin
            if (buzz_next) beep_next = sps_pkg::BEEP_TWO;
            timer_on_next = 1'b1;
          end
          mode_next = sps_pkg::MODE_RUNNING;
        end
        if (pause) begin
          timer_on_next = 1'b0;
          mode_next = sps_pkg::MODE_PAUSE;
          pause_ticks_next = 17'd0;
          if (buzz_next) beep_next = sps_pkg::BEEP_TWO;
        end
        if (sleep) begin
          timer_on_next = 1'b0;
          if (buzz_next) beep_next = sps_pkg::BEEP_LONG;
          mode_next = sps_pkg::MODE_SLEEP;
        end
      end
      default: ;
    endcase

    // result item
    sel = (mode_next != sps_pkg::MODE_SLEEP) && led_lit_next;
    result.pad             = 2'd0;
    result.device_mode     = mode_next;
    result.phase_number    = phase_next;
    result.period_value    = sps_pkg::period_of(phase_next);
    result.period_timer_on = timer_on_next;
    result.level_low       = low_code_next;
    result.level_high      = high_code_next;
    result.short_wave      = wave_next;
    result.buzzer_on       = buzz_next;
    result.led_long        = wave_next ? 1'b0 : sel;
    result.led_short       = wave_next ? sel : 1'b0;
    result.beep_kind       = beep_next;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= sps_pkg::MODE_SLEEP;
      phase_reg   <= 5'd0;
      phase_ticks <= 16'd0;
      phase_units <= 9'd0;
      low_code    <= 12'd0;
      high_code   <= sps_pkg::HIGH_CODE_RST;
      wave_reg    <= 1'b0;
      buzz_enable <= 1'b1;
      press_ticks <= 10'd0;
      press_armed <= 1'b0;
      pause_ticks <= 17'd0;
      flash_ticks <= 7'd0;
      flash_level <= 1'b0;
      timer_on    <= 1'b0;
      led_lit     <= 1'b0;
    end else if (advance) begin
      mode_reg    <= mode_next;
      phase_reg   <= phase_next;
      phase_ticks <= phase_ticks_next;
      phase_units <= phase_units_next;
      low_code    <= low_code_next;
      high_code   <= high_code_next;
      wave_reg    <= wave_next;
      buzz_enable <= buzz_next;
      press_ticks <= press_ticks_next;
      press_armed <= press_armed_next;
      pause_ticks <= pause_ticks_next;
      flash_ticks <= flash_ticks_next;
      flash_level <= flash_level_next;
      timer_on    <= timer_on_next;
      led_lit     <= led_lit_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) m_tdata <= result;
  end

  // checks on the sequencer's own logic
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    int'(phase_reg) < NUM_PHASES)
    else $error("phase register beyond the last phase");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled while a stage could take it");

  a_sleep_dark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == sps_pkg::MODE_SLEEP) |-> (m_tdata[51:50] == 2'b00))
    else $error("led lit in sleep");

  a_beep_needs_buzzer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[53:52] != sps_pkg::BEEP_NONE) |-> m_tdata[49])
    else $error("beep requested with buzzer disabled");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode_reg) && $stable(phase_reg) && $stable(press_armed))
    else $error("state changed without an evaluated item");

endmodule
